>>> rtl/stsc_pkg.sv
`default_nettype none
package stsc_pkg;

  typedef enum logic [1:0] {
    MODE_COMMAND = 2'd0,
    MODE_TARGET  = 2'd1,
    MODE_PAYLOAD = 2'd2
  } mode_t;

  localparam logic [1:0] ACT_DESELECT = 2'd0;
  localparam logic [1:0] ACT_READ     = 2'd1;
  localparam logic [1:0] ACT_WRITESEL = 2'd2;
  localparam logic [1:0] ACT_WBYTE    = 2'd3;

  localparam logic [7:0] CMD_DESELECT = 8'h00;
  localparam logic [7:0] CMD_PREFIX   = 8'h80;
  localparam logic [7:0] TARGET_MAX   = 8'h02;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] target;
    logic [6:0] read_count;
    logic [7:0] write_byte;
    logic       last_byte;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/serial_to_spi_command_parser.sv
// an accepted beat is held in the input register and parsed; its result is registered in the output register for out_
// throughput: one byte per cycle; the input register holds only while the output
// register is full and stalled and the held byte gives a result
// reset: synchronous active-low rst_n returns the parser to command state, target
// zero, zero payload length and count, and empties both registers
`default_nettype none
module serial_to_spi_command_parser
  import stsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_action,
  output logic [1:0]      out_target,
  output logic [6:0]      out_read_count,
  output logic [7:0]      out_write_byte,
  output logic            out_last_byte
);

  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       out_valid_r;
  result_t    res_r;
  result_t    res;
  logic       res_valid;
  logic       out_free;
  logic       go;

  assign out_free = !out_valid_r || !out_stall;
  assign go       = in_valid_r && (!res_valid || out_free);
  assign in_stall = in_valid_r && !go;

  stsc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .byte_in   (byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) byte_r <= in_byte_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= go && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && go && res_valid) res_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_action     = res_r.action;
  assign out_target     = res_r.target;
  assign out_read_count = res_r.read_count;
  assign out_write_byte = res_r.write_byte;
  assign out_last_byte  = res_r.last_byte;

endmodule
`default_nettype wire

>>> rtl/stsc_parse.sv
`default_nettype none
module stsc_parse
  import stsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       go,
  input  wire logic [7:0] byte_in,
  output logic            res_valid,
  output result_t         res
);

  mode_t      mode_r, mode_nxt;
  logic [1:0] target_r, target_nxt;
  logic [6:0] length_r, length_nxt;
  logic [6:0] count_r, count_nxt;
  logic [6:0] count_inc;
  logic       last;

  assign count_inc = count_r + 7'd1;
  assign last      = (count_inc == length_r);

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    target_nxt = target_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    case (mode_r)
      MODE_TARGET: begin
        if (byte_in <= TARGET_MAX) target_nxt = byte_in[1:0];
        mode_nxt = MODE_COMMAND;
      end
      MODE_PAYLOAD: begin
        count_nxt = count_inc;
        if (last) begin
          length_nxt = 7'd0;
          count_nxt  = 7'd0;
          mode_nxt   = MODE_COMMAND;
        end
      end
      default: begin
        mode_nxt = MODE_COMMAND;
        if (byte_in == CMD_PREFIX) begin
          mode_nxt = MODE_TARGET;
        end else if (byte_in != CMD_DESELECT && !byte_in[7]) begin
          length_nxt = byte_in[6:0];
          count_nxt  = 7'd0;
          mode_nxt   = MODE_PAYLOAD;
        end
      end
    endcase
  end

  // result
  always_comb begin
    res_valid      = 1'b1;
    res.action     = ACT_DESELECT;
    res.target     = target_r;
    res.read_count = 7'd0;
    res.write_byte = 8'd0;
    res.last_byte  = 1'b0;
    case (mode_r)
      MODE_TARGET: begin
        res_valid = 1'b0;
      end
      MODE_PAYLOAD: begin
        res.action     = ACT_WBYTE;
        res.write_byte = byte_in;
        res.last_byte  = last;
      end
      default: begin
        if (byte_in == CMD_DESELECT) begin
          res.action = ACT_DESELECT;
        end else if (byte_in == CMD_PREFIX) begin
          res_valid = 1'b0;
        end else if (byte_in[7]) begin
          res.action     = ACT_READ;
          res.read_count = byte_in[6:0];
        end else begin
          res.action = ACT_WRITESEL;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_COMMAND;
      target_r <= 2'd0;
      length_r <= 7'd0;
      count_r  <= 7'd0;
    end else if (go) begin
      mode_r   <= mode_nxt;
      target_r <= target_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sim/tb_serial_to_spi_command_parser.sv
`timescale 1ns / 100ps

import stsc_pkg::*;

class spi_action_tracker;
  mode_t      mode;
  logic [1:0] chip_sel;
  logic [6:0] payload_len;
  logic [6:0] payload_cnt;
  result_t    due_actions[$];
  int         mismatches;

  function new();
    mode        = MODE_COMMAND;
    chip_sel    = 2'd0;
    payload_len = 7'd0;
    payload_cnt = 7'd0;
    mismatches  = 0;
  endfunction

  function int pending();
    return due_actions.size();
  endfunction

  function void note_byte(logic [7:0] b);
    result_t r;
    r = '0;
    if (mode == MODE_TARGET) begin
      if (b <= TARGET_MAX) begin
        chip_sel = b[1:0];
      end
      mode = MODE_COMMAND;
    end else if (mode == MODE_PAYLOAD) begin
      payload_cnt  = payload_cnt + 7'd1;
      r.action     = ACT_WBYTE;
      r.target     = chip_sel;
      r.write_byte = b;
      r.last_byte  = (payload_cnt == payload_len);
      if (r.last_byte) begin
        payload_len = 7'd0;
        payload_cnt = 7'd0;
        mode        = MODE_COMMAND;
      end
      due_actions.push_back(r);
    end else begin
      mode = MODE_COMMAND;
      if (b == CMD_DESELECT) begin
        r.action = ACT_DESELECT;
        r.target = chip_sel;
        due_actions.push_back(r);
      end else if (b == CMD_PREFIX) begin
        mode = MODE_TARGET;
      end else if (b[7]) begin
        r.action     = ACT_READ;
        r.target     = chip_sel;
        r.read_count = b[6:0];
        due_actions.push_back(r);
      end else begin
        payload_len = b[6:0];
        payload_cnt = 7'd0;
        mode        = MODE_PAYLOAD;
        r.action    = ACT_WRITESEL;
        r.target    = chip_sel;
        due_actions.push_back(r);
      end
    end
  endfunction

  function void compare_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      mismatches++;
    end
  endfunction

  function void check_action(result_t got);
    result_t e;
    if (due_actions.size() == 0) begin
      $display("%0t: unexpected beat, expected none actual %0h", $time, got);
      mismatches++;
    end else begin
      e = due_actions.pop_front();
      compare_field("action", e.action, got.action);
      compare_field("target", e.target, got.target);
      compare_field("read_count", e.read_count, got.read_count);
      compare_field("write_byte", e.write_byte, got.write_byte);
      compare_field("last_byte", e.last_byte, got.last_byte);
    end
  endfunction
endclass

module tb_serial_to_spi_command_parser;
  import stsc_pkg::*;

  localparam int NUM_BYTES = 1850;
  localparam int OPENING_LEN = 23;
  localparam logic [7:0] OPENING [OPENING_LEN] = '{
    CMD_DESELECT,
    CMD_PREFIX, 8'h02,
    CMD_PREFIX | 8'h7F,
    CMD_PREFIX, 8'h01,
    CMD_PREFIX | 8'h01,
    CMD_PREFIX, 8'h03,
    CMD_PREFIX, 8'hFF,
    CMD_DESELECT,
    CMD_PREFIX, 8'h00,
    8'h01, 8'hFF,
    8'h02, CMD_DESELECT, CMD_PREFIX,
    8'h03, CMD_PREFIX, CMD_DESELECT, 8'h7F
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_action;
  logic [1:0] out_target;
  logic [6:0] out_read_count;
  logic [7:0] out_write_byte;
  logic       out_last_byte;

  spi_action_tracker tracker = new();
  bit calm = 1'b0;
  int bytes_sent = 0;

  serial_to_spi_command_parser dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_in    (in_byte_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .out_target    (out_target),
    .out_read_count(out_read_count),
    .out_write_byte(out_write_byte),
    .out_last_byte (out_last_byte)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 23);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_write(input int unsigned len);
    send_byte(len[7:0]);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_sequence();
    int unsigned k;
    int unsigned pick;
    k = $urandom_range(0, 99);
    if (k < 12) begin
      send_byte(CMD_DESELECT);
    end else if (k < 30) begin
      send_byte(CMD_PREFIX);
      pick = $urandom_range(0, 9);
      send_byte(8'(pick < 7 ? pick % 3 : $urandom_range(3, 255)));
    end else if (k < 50) begin
      send_byte(CMD_PREFIX | 8'($urandom_range(1, 127)));
    end else if (k < 90) begin
      if ($urandom_range(0, 19) == 0) begin
        send_write($urandom_range(9, 127));
      end else begin
        send_write($urandom_range(1, 8));
      end
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_action('{out_action, out_target, out_read_count,
                             out_write_byte, out_last_byte});
    end
    out_stall <= rst_n && take_break();
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (OPENING[i]) begin
      send_byte(OPENING[i]);
    end
    send_write(127);
    while (bytes_sent < NUM_BYTES) begin
      calm = (bytes_sent >= 700) && (bytes_sent < 1000);
      send_sequence();
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
rtl/stsc_pkg.sv
rtl/stsc_parse.sv
rtl/serial_to_spi_command_parser.sv
sim/tb_serial_to_spi_command_parser.sv
